>>> rtl/core/oebs_pkg.sv
package oebs_pkg;

  localparam int SAMPLE_W   = 8;
  localparam int ENERGY_W   = 16;
  localparam int SUM_W      = 32;
  localparam int SPB_W      = 16;
  localparam int THRESH_W   = 31;
  localparam int POS_W      = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 31;

  // Largest squared magnitude: (-128)^2 + (-128)^2.
  localparam logic [ENERGY_W-1:0] MAX_ENERGY = 16'd32768;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LEN     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_THRESHOLD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_THRESHOLD  = 2'd2;

  localparam logic [SPB_W-1:0]    SPB_RESET  = 16'd1000;
  localparam logic [THRESH_W-1:0] HIGH_RESET = 31'd6400000;
  localparam logic [THRESH_W-1:0] LOW_RESET  = 31'd3200000;

  typedef struct packed {
    logic [SPB_W-1:0]    window_len;
    logic [THRESH_W-1:0] high_threshold;
    logic [THRESH_W-1:0] low_threshold;
  } cfg_t;

  typedef struct packed {
    logic                valid;
    logic [ENERGY_W-1:0] energy;
  } energy_req_t;

endpackage

>>> rtl/core/oebs_ifs.sv
interface oebs_sample_if;
  import oebs_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] in_phase;
  logic signed [SAMPLE_W-1:0] quadrature;

  modport source (output valid, output in_phase, output quadrature, input ready);
  modport sink (input valid, input in_phase, input quadrature, output ready);
endinterface

interface oebs_bit_if;
  import oebs_pkg::*;

  logic             valid;
  logic             ready;
  logic             bit_value;
  logic [POS_W-1:0] bit_position;
  logic             packet_last;

  modport source (output valid, output bit_value, output bit_position,
                  output packet_last, input ready);
  modport sink (input valid, input bit_value, input bit_position,
                input packet_last, output ready);
endinterface

>>> rtl/core/oebs_energy.sv
module oebs_energy (
  input  logic                 clk,
  input  logic                 rst,
  oebs_sample_if.sink          sample_in,
  output oebs_pkg::energy_req_t energy_req,
  input  logic                 energy_take
);
  import oebs_pkg::*;

  logic                       a_valid;
  logic signed [SAMPLE_W-1:0] a_i;
  logic signed [SAMPLE_W-1:0] a_q;
  logic                       e_valid;
  logic [ENERGY_W-1:0]        energy;

  logic                       e_free;
  logic signed [2*SAMPLE_W-1:0] sq_i;
  logic signed [2*SAMPLE_W-1:0] sq_q;
  logic [ENERGY_W-1:0]        energy_next;

  assign e_free          = !e_valid || energy_take;
  assign sample_in.ready = !a_valid || e_free;

  // Both squares are non-negative and at most 16384, so their sum fits unsigned.
  assign sq_i        = a_i * a_i;
  assign sq_q        = a_q * a_q;
  assign energy_next = ENERGY_W'(unsigned'(sq_i)) + ENERGY_W'(unsigned'(sq_q));

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      e_valid <= 1'b0;
    end else begin
      if (sample_in.valid && sample_in.ready) begin
        a_valid <= 1'b1;
      end else if (e_free) begin
        a_valid <= 1'b0;
      end
      if (e_free) begin
        e_valid <= a_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sample_in.valid && sample_in.ready) begin
      a_i <= sample_in.in_phase;
      a_q <= sample_in.quadrature;
    end
    if (e_free && a_valid) begin
      energy <= energy_next;
    end
  end

  assign energy_req.valid  = e_valid;
  assign energy_req.energy = energy;

  a_energy_range: assert property (@(posedge clk) disable iff (rst)
    e_valid |-> energy <= MAX_ENERGY)
    else $error("energy register above the largest squared magnitude");

  a_input_held: assert property (@(posedge clk) disable iff (rst)
    a_valid && !e_free |=> a_valid && $stable(a_i) && $stable(a_q))
    else $error("input register lost a request while the energy stage was full");

  a_energy_held: assert property (@(posedge clk) disable iff (rst)
    e_valid && !energy_take |=> e_valid && $stable(energy))
    else $error("energy register changed while the slicer held it off");

endmodule

>>> rtl/core/oebs_slicer.sv
module oebs_slicer #(
  parameter int PACKET_BITS = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  input  oebs_pkg::cfg_t        cfg,
  input  oebs_pkg::energy_req_t energy_req,
  output logic                  energy_take,
  oebs_bit_if.source            bit_out
);
  import oebs_pkg::*;

  localparam int PW  = (PACKET_BITS > 1) ? $clog2(PACKET_BITS) : 1;
  localparam int PXW = (PW > POS_W) ? PW : POS_W;
  localparam logic [PW-1:0] LAST_INDEX = PW'(PACKET_BITS - 1);

  logic [SPB_W-1:0]  window_count;
  logic [SUM_W-1:0]  energy_sum;
  logic              held_bit;
  logic [PW-1:0]     packet_index;
  logic              out_valid;
  logic              out_bit;
  logic [POS_W-1:0]  out_pos;
  logic              out_last;

  logic [SPB_W:0]    filled;
  logic              complete;
  logic [SUM_W-1:0]  sum_next;
  logic              bit_next;
  logic              last;
  logic              stall;
  logic [PXW-1:0]    index_ext;

  assign filled   = {1'b0, window_count} + (SPB_W + 1)'(1);
  // A length of zero behaves like one, since filled is never below one.
  assign complete = filled >= {1'b0, cfg.window_len};
  assign sum_next = energy_sum + SUM_W'(energy_req.energy);

  always_comb begin
    if (sum_next > {1'b0, cfg.high_threshold}) begin
      bit_next = 1'b1;
    end else if (sum_next < {1'b0, cfg.low_threshold}) begin
      bit_next = 1'b0;
    end else begin
      bit_next = held_bit;
    end
  end

  assign last      = packet_index == LAST_INDEX;
  assign index_ext = PXW'(packet_index);

  // Only a closing sample needs the output register, so partial sums keep
  // flowing while a finished bit waits downstream.
  assign stall       = energy_req.valid && complete && out_valid && !bit_out.ready;
  assign energy_take = energy_req.valid && !stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_count <= '0;
      energy_sum   <= '0;
      held_bit     <= 1'b0;
      packet_index <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (energy_take && complete) begin
        window_count <= '0;
        energy_sum   <= '0;
        held_bit     <= bit_next;
        packet_index <= last ? '0 : packet_index + PW'(1);
        out_valid    <= 1'b1;
      end else begin
        if (energy_take) begin
          window_count <= filled[SPB_W-1:0];
          energy_sum   <= sum_next;
        end
        if (bit_out.ready) begin
          out_valid <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (energy_take && complete) begin
      out_bit  <= bit_next;
      out_pos  <= index_ext[POS_W-1:0];
      out_last <= last;
    end
  end

  assign bit_out.valid        = out_valid;
  assign bit_out.bit_value    = out_bit;
  assign bit_out.bit_position = out_pos;
  assign bit_out.packet_last  = out_last;

  a_index_range: assert property (@(posedge clk) disable iff (rst)
    packet_index <= LAST_INDEX)
    else $error("packet index ran past the packet length");

  a_window_cleared: assert property (@(posedge clk) disable iff (rst)
    energy_take && complete |=> window_count == '0 && energy_sum == '0)
    else $error("window not cleared after a bit decision");

  a_last_position: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_last |-> out_pos == POS_W'(PACKET_BITS - 1))
    else $error("packet end flagged at the wrong bit position");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && !bit_out.ready |=> out_valid && $stable(out_bit) && $stable(out_pos))
    else $error("pending result overwritten before it was taken");

endmodule

>>> rtl/core/ook_energy_bit_slicer.sv
// A result is written to the output register once the sample closing its bit window has
// passed the input register and the energy register; a stall can hold it in either.
// Throughput: one sample per cycle, set by the accumulate-and-compare loop;
// intake stalls only when a finished bit has not yet been taken downstream.
// Reset (rst, synchronous): clears the window, held bit and packet position, empties
// the pipeline and restores the register defaults of 1000, 6400000 and 3200000.
module ook_energy_bit_slicer #(
  parameter int PACKET_BITS = 4
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [oebs_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [oebs_pkg::CFG_DATA_W-1:0]      cfg_data,
  oebs_sample_if.sink                          sample_in,
  oebs_bit_if.source                           bit_out
);
  import oebs_pkg::*;

  cfg_t        cfg;
  energy_req_t energy_req;
  logic        energy_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.window_len     <= SPB_RESET;
      cfg.high_threshold <= HIGH_RESET;
      cfg.low_threshold  <= LOW_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WINDOW_LEN:     cfg.window_len     <= cfg_data[SPB_W-1:0];
        CFG_HIGH_THRESHOLD: cfg.high_threshold <= cfg_data[THRESH_W-1:0];
        CFG_LOW_THRESHOLD:  cfg.low_threshold  <= cfg_data[THRESH_W-1:0];
        default: ;
      endcase
    end
  end

  oebs_energy u_energy (
    .clk         (clk),
    .rst         (rst),
    .sample_in   (sample_in),
    .energy_req  (energy_req),
    .energy_take (energy_take)
  );

  oebs_slicer #(
    .PACKET_BITS (PACKET_BITS)
  ) u_slicer (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .energy_req  (energy_req),
    .energy_take (energy_take),
    .bit_out     (bit_out)
  );

endmodule

>>> test/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import oebs_pkg::*;

  localparam int PACKET_BITS = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam int DRAIN_CYCLES = 8;
  localparam int STALL_LIMIT = 2000;

  typedef struct packed {
    logic             value;
    logic [POS_W-1:0] pos;
    logic             last;
  } bit_rec_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  oebs_sample_if sample_ch ();
  oebs_bit_if bit_ch ();

  ook_energy_bit_slicer #(
    .PACKET_BITS(PACKET_BITS)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .sample_in(sample_ch),
    .bit_out(bit_ch)
  );

  // Predictor state: register copy plus the window and packet progress.
  cfg_t slicer_cfg;
  logic [SPB_W-1:0] win_fill;
  logic [SUM_W-1:0] win_energy;
  logic last_bit;
  int pkt_pos;

  bit_rec_t pending_bits[$];
  int mismatches;
  int idle_cycles;
  bit steady;

  initial begin
    clk = 1'b0;
  end

  always #2 clk = ~clk;

  function automatic void slice_sample(input int i_s, input int q_s);
    int iv;
    int qv;
    logic [SUM_W-1:0] energy;
    logic [SPB_W:0] filled;
    bit_rec_t rec;
    iv = int'(SAMPLE_W'(i_s));
    qv = int'(SAMPLE_W'(q_s));
    energy = SUM_W'(iv * iv + qv * qv);
    win_energy = win_energy + energy;
    filled = {1'b0, win_fill} + (SPB_W + 1)'(1);
    // A window shortened below the current fill closes on this sample.
    if (filled < {1'b0, slicer_cfg.window_len}) begin
      win_fill = filled[SPB_W-1:0];
      return;
    end
    // Equal to a threshold keeps the held bit if low <= high; above high wins if low > high.
    if (win_energy > {1'b0, slicer_cfg.high_threshold}) begin
      last_bit = 1'b1;
    end else if (win_energy < {1'b0, slicer_cfg.low_threshold}) begin
      last_bit = 1'b0;
    end
    rec.value = last_bit;
    rec.pos = pkt_pos[POS_W-1:0];
    rec.last = (pkt_pos + 1 >= PACKET_BITS);
    pending_bits.push_back(rec);
    pkt_pos = rec.last ? 0 : pkt_pos + 1;
    win_fill = '0;
    win_energy = '0;
  endfunction

  function automatic int rand_sample(input bit on_air);
    int mag;
    if ($urandom_range(99) < 15) begin
      return int'($urandom_range(255)) - 128;
    end
    mag = on_air ? $urandom_range(50, 127) : $urandom_range(0, 12);
    if ($urandom_range(1) == 1) begin
      mag = -mag;
    end
    if (mag == -127 && $urandom_range(3) == 0) begin
      mag = -128;
    end
    return mag;
  endfunction

  task automatic send_sample(input int i_s, input int q_s);
    while (!steady && $urandom_range(99) < 30) begin
      sample_ch.valid <= 1'b0;
      @(posedge clk);
    end
    sample_ch.valid <= 1'b1;
    sample_ch.in_phase <= SAMPLE_W'(i_s);
    sample_ch.quadrature <= SAMPLE_W'(q_s);
    @(posedge clk);
    while (!sample_ch.ready) @(posedge clk);
    slice_sample(i_s, q_s);
  endtask

  // Samples still in flight may close no window, so keep waiting after the last bit.
  task automatic drain_bits();
    sample_ch.valid <= 1'b0;
    while (pending_bits.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_DATA_W'(data);
    @(posedge clk);
    case (idx)
      CFG_WINDOW_LEN: slicer_cfg.window_len = data[SPB_W-1:0];
      CFG_HIGH_THRESHOLD: slicer_cfg.high_threshold = data[THRESH_W-1:0];
      CFG_LOW_THRESHOLD: slicer_cfg.low_threshold = data[THRESH_W-1:0];
      default: ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Reset registers: 200 full-scale samples stay inside the 1000-sample window.
  // Shortening the window then closes it on the next sample, above the high threshold.
  task automatic test_default_window();
    repeat (200) send_sample(-128, -128);
    drain_bits();
    write_reg(CFG_WINDOW_LEN, 200);
    send_sample(127, -128);
    drain_bits();
  endtask

  task automatic test_single_sample_bits();
    write_reg(CFG_WINDOW_LEN, 1);
    write_reg(CFG_HIGH_THRESHOLD, 1000);
    write_reg(CFG_LOW_THRESHOLD, 500);
    send_sample(0, 0);
    send_sample(30, 10);
    send_sample(-128, -128);
    send_sample(127, 127);
    send_sample(20, -10);
    send_sample(-1, -1);
    send_sample(-32, 0);
    send_sample(22, 0);
    send_sample(85, -86);
    send_sample(-43, 42);
    send_sample(1, 1);
    drain_bits();
    // A zero window length behaves like one.
    write_reg(CFG_WINDOW_LEN, 0);
    send_sample(31, 0);
    send_sample(127, -128);
    send_sample(0, 1);
    drain_bits();
    write_reg(CFG_HIGH_THRESHOLD, 100);
    write_reg(CFG_LOW_THRESHOLD, 5000);
    send_sample(40, 20);
    send_sample(7, 1);
    send_sample(30, 0);
    drain_bits();
    write_reg(CFG_HIGH_THRESHOLD, 0);
    write_reg(CFG_LOW_THRESHOLD, 0);
    send_sample(0, 0);
    send_sample(0, 1);
    drain_bits();
  endtask

  task automatic test_window_shrink();
    write_reg(CFG_WINDOW_LEN, 8);
    write_reg(CFG_HIGH_THRESHOLD, 2000);
    write_reg(CFG_LOW_THRESHOLD, 1000);
    repeat (5) send_sample(10, 10);
    drain_bits();
    write_reg(CFG_WINDOW_LEN, 3);
    send_sample(10, 10);
    drain_bits();
    write_reg(CFG_UNUSED, 1);
    repeat (3) send_sample(-10, 10);
    drain_bits();
  endtask

  // Full-scale samples against thresholds with the top bits set; 40 of them sum to
  // one above the first high threshold, and the low threshold sits above both.
  task automatic test_full_scale();
    write_reg(CFG_WINDOW_LEN, 40);
    write_reg(CFG_HIGH_THRESHOLD, 32'h0013FFFF);
    write_reg(CFG_LOW_THRESHOLD, 32'h7FFFFFFF);
    repeat (40) send_sample(-128, -128);
    drain_bits();
    write_reg(CFG_HIGH_THRESHOLD, 32'h7FFFFFFF);
    repeat (40) send_sample(-128, -128);
    drain_bits();
  endtask

  task automatic test_random_traffic();
    int spb;
    bit on_air;
    int i_s;
    int q_s;
    for (int phase = 0; phase < 5; phase++) begin
      spb = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      write_reg(CFG_WINDOW_LEN, spb);
      if ($urandom_range(4) == 0) begin
        write_reg(CFG_HIGH_THRESHOLD, int'($urandom));
        write_reg(CFG_LOW_THRESHOLD, int'($urandom));
      end else begin
        write_reg(CFG_HIGH_THRESHOLD, spb * int'($urandom_range(3000, 14000)));
        write_reg(CFG_LOW_THRESHOLD, spb * int'($urandom_range(200, 9000)));
      end
      steady = (phase == 3);
      on_air = $urandom_range(1);
      for (int n = 0; n < 100; n++) begin
        if ($urandom_range(spb) == 0) begin
          on_air = !on_air;
        end
        i_s = rand_sample(on_air);
        q_s = rand_sample(on_air);
        send_sample(i_s, q_s);
        if ((phase == 0 && n == 50) || $urandom_range(99) == 0) begin
          drain_bits();
        end
      end
      steady = 1'b0;
      drain_bits();
    end
  endtask

  always @(posedge clk) begin
    bit_rec_t exp_bit;
    if (rst) begin
      bit_ch.ready <= 1'b0;
    end else begin
      bit_ch.ready <= steady || ($urandom_range(99) >= 30);
    end
    if (!rst && bit_ch.valid && bit_ch.ready) begin
      if (pending_bits.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected bit: value %0d pos %0d last %0d",
                   bit_ch.bit_value, bit_ch.bit_position, bit_ch.packet_last);
        end
      end else begin
        exp_bit = pending_bits.pop_front();
        if (exp_bit.value !== bit_ch.bit_value || exp_bit.pos !== bit_ch.bit_position ||
            exp_bit.last !== bit_ch.packet_last) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("bit mismatch: expected value %0d pos %0d last %0d, got %0d %0d %0d",
                     exp_bit.value, exp_bit.pos, exp_bit.last,
                     bit_ch.bit_value, bit_ch.bit_position, bit_ch.packet_last);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (sample_ch.valid && sample_ch.ready) || (bit_ch.valid && bit_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("ook_energy_bit_slicer test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= CFG_WINDOW_LEN;
    cfg_data <= '0;
    sample_ch.valid <= 1'b0;
    sample_ch.in_phase <= '0;
    sample_ch.quadrature <= '0;
    mismatches = 0;
    steady = 1'b0;
    slicer_cfg.window_len = SPB_RESET;
    slicer_cfg.high_threshold = HIGH_RESET;
    slicer_cfg.low_threshold = LOW_RESET;
    win_fill = '0;
    win_energy = '0;
    last_bit = 1'b0;
    pkt_pos = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_default_window();
    test_single_sample_bits();
    test_window_shrink();
    test_full_scale();
    test_random_traffic();
    drain_bits();
    if (mismatches == 0) begin
      $display("ook_energy_bit_slicer test passed");
    end else begin
      $display("ook_energy_bit_slicer test failed");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/oebs_pkg.sv
rtl/core/oebs_ifs.sv
rtl/core/oebs_energy.sv
rtl/core/oebs_slicer.sv
rtl/core/ook_energy_bit_slicer.sv
test/testbench.sv
